[hdl/pcfi_pkg.sv]
// Shared types, constants and arithmetic helpers of the particle contact force integrator.
package pcfi_pkg;

  localparam int DEFAULT_PARTICLES = 256;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_STIFFNESS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIME_STEP = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INV_DOUBLE_STEP = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_INV_MASS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_VERLET_MODE = 3'd4;

  localparam logic [31:0] RST_STIFFNESS = 32'd65536000;
  localparam logic [31:0] RST_TIME_STEP = 32'd4294967;
  localparam logic [31:0] RST_INV_DOUBLE_STEP = 32'd32768000;
  localparam logic [31:0] RST_INV_MASS = 32'd65536;

  localparam logic signed [65:0] SAT_MAX66 = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN66 = -66'sd2147483648;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_CONTACT = 2'd2,
    CMD_MOVE    = 2'd3
  } pcfi_cmd_t;

  typedef enum logic [5:0] {
    S_IDLE, S_MWAIT, S_DONE,
    S_LD_MUL, S_LD_WR, S_CLR,
    S_MV_RD, S_MV_ACC, S_MV_AT, S_MV_VB, S_MV_VC, S_MV_VD, S_MV_E1, S_MV_E2,
    S_CT_RA, S_CT_RB, S_CT_RS, S_CT_PA, S_CT_PB, S_CT_D,
    S_CT_BG, S_CT_BG2, S_CT_SQ, S_CT_SQ2, S_CT_ROOT,
    S_CT_F0, S_CT_F1, S_CT_F2, S_CT_F3, S_CT_F4, S_CT_F5
  } pcfi_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX66) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_MIN66) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [65:0] sx66(input logic signed [31:0] v);
    return {{34{v[31]}}, v};
  endfunction

  function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

endpackage

[hdl/particle_contact_force_integrator_top.sv]
// Top level of the particle contact force integrator: particle memories, command sequencer and datapath.
//
// The block holds PARTICLES particles in on-chip memories (position, previous position,
// velocity and force, three words per particle each, plus one radius word) and executes one
// command per input transfer, answering with exactly one result transfer. Commands run one at
// a time through a sequencer that steps axis by axis over a shared 33x32 multiplier with a
// registered product. A contact whose spheres touch also runs a square root unit and then a
// divider (one division per axis). A new command is taken while the previous result still
// waits in the output register. Entries are undefined until a particle is loaded, so no
// clearing pass runs after reset. Configuration writes take effect at once and should be
// made while no command is in flight.
module particle_contact_force_integrator_top #(
  parameter int PARTICLES = pcfi_pkg::DEFAULT_PARTICLES
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [pcfi_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [pcfi_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  cmd_valid,
  output logic                                  cmd_ready,
  input  logic [1:0]                            command,
  input  logic [7:0]                            index_a,
  input  logic [7:0]                            index_b,
  input  logic signed [31:0]                    pos_x,
  input  logic signed [31:0]                    pos_y,
  input  logic signed [31:0]                    pos_z,
  input  logic signed [31:0]                    vel_x,
  input  logic signed [31:0]                    vel_y,
  input  logic signed [31:0]                    vel_z,
  input  logic [30:0]                           radius,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output logic [1:0]                            kind,
  output logic                                  in_contact,
  output logic signed [31:0]                    force_x,
  output logic signed [31:0]                    force_y,
  output logic signed [31:0]                    force_z,
  output logic signed [31:0]                    new_x,
  output logic signed [31:0]                    new_y,
  output logic signed [31:0]                    new_z,
  output logic signed [31:0]                    new_vx,
  output logic signed [31:0]                    new_vy,
  output logic signed [31:0]                    new_vz
);
  import pcfi_pkg::*;

  localparam int MEM_DEPTH = 3 * PARTICLES;
  localparam int AW = $clog2(MEM_DEPTH);
  localparam int RW = $clog2(PARTICLES);

  // Configuration registers.
  logic [31:0] stiffness, time_step, inv_double_step, inv_mass;
  logic        verlet_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness       <= RST_STIFFNESS;
      time_step       <= RST_TIME_STEP;
      inv_double_step <= RST_INV_DOUBLE_STEP;
      inv_mass        <= RST_INV_MASS;
      verlet_mode     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STIFFNESS:       stiffness       <= cfg_data;
        CFG_TIME_STEP:       time_step       <= cfg_data;
        CFG_INV_DOUBLE_STEP: inv_double_step <= cfg_data;
        CFG_INV_MASS:        inv_mass        <= cfg_data;
        CFG_VERLET_MODE:     verlet_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pcfi_state_t state, state_next;

  // Latched command.
  logic [1:0]  cmd_r;
  logic [7:0]  a_r, b_r;
  logic [AW-1:0] base_a, base_b, addr_a, addr_b;
  logic [1:0]  ax;
  logic signed [31:0] pos_in [3];
  logic signed [31:0] vel_in [3];
  logic [30:0] rad_in;
  logic        in_range;
  logic        accept;

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign in_range  = (32'(index_a) < 32'(PARTICLES)) &&
                     ((command != CMD_CONTACT) || (32'(index_b) < 32'(PARTICLES)));
  assign addr_a    = base_a + AW'(ax);
  assign addr_b    = base_b + AW'(ax);

  // Memories: one read port with registered data and one write port each.
  logic [31:0] pos_mem  [MEM_DEPTH];
  logic [31:0] prev_mem [MEM_DEPTH];
  logic [31:0] vel_mem  [MEM_DEPTH];
  logic [31:0] frc_mem  [MEM_DEPTH];
  logic [30:0] rad_mem  [PARTICLES];

  logic [AW-1:0] pos_raddr, frc_raddr, mem_waddr, frc_waddr;
  logic [RW-1:0] rad_raddr;
  logic          pos_we, prev_we, vel_we, frc_we, rad_we;
  logic signed [31:0] pos_wdata, prev_wdata, vel_wdata, frc_wdata;
  logic signed [31:0] pos_rd, prev_rd, vel_rd, frc_rd;
  logic [30:0]   rad_rd;

  always_ff @(posedge clk) begin
    pos_rd <= pos_mem[pos_raddr];
    if (pos_we) pos_mem[mem_waddr] <= pos_wdata;
  end
  always_ff @(posedge clk) begin
    prev_rd <= prev_mem[addr_a];
    if (prev_we) prev_mem[mem_waddr] <= prev_wdata;
  end
  always_ff @(posedge clk) begin
    vel_rd <= vel_mem[addr_a];
    if (vel_we) vel_mem[mem_waddr] <= vel_wdata;
  end
  always_ff @(posedge clk) begin
    frc_rd <= frc_mem[frc_raddr];
    if (frc_we) frc_mem[frc_waddr] <= frc_wdata;
  end
  always_ff @(posedge clk) begin
    rad_rd <= rad_mem[rad_raddr];
    if (rad_we) rad_mem[RW'(a_r)] <= rad_in;
  end

  // Shared multiplier: operands registered at issue, then the product registered from them,
  // rounding to nearest (ties away from zero) applied on the way out.
  logic                mul_go, mi_s32, mul_s32, mul_neg;
  logic signed [32:0]  mi_a, mul_a;
  logic [31:0]         mi_b, mul_b;
  pcfi_state_t         mi_ret, mul_ret;
  logic [32:0]         mul_mag;
  logic [64:0]         mul_p;
  logic [65:0]         rnd16, rnd32, rsel;
  logic signed [65:0]  mul_res;

  assign mul_mag = mul_a[32] ? 33'(~mul_a + 33'd1) : mul_a;

  always_ff @(posedge clk) begin
    if (mul_go) begin
      mul_a   <= mi_a;
      mul_b   <= mi_b;
      mul_s32 <= mi_s32;
      mul_ret <= mi_ret;
    end
    mul_p   <= {32'd0, mul_mag} * {33'd0, mul_b};
    mul_neg <= mul_a[32];
  end

  assign rnd16   = ({1'b0, mul_p} + 66'h8000) >> 16;
  assign rnd32   = ({1'b0, mul_p} + 66'h8000_0000) >> 32;
  assign rsel    = mul_s32 ? rnd32 : rnd16;
  assign mul_res = mul_neg ? -$signed(rsel) : $signed(rsel);

  // Square root and divider for the contact normal.
  logic        sqrt_go, sqrt_done, div_go, div_done;
  logic [63:0] sqrt_arg;
  logic [31:0] sqrt_root, div_q;
  logic [64:0] div_num;
  logic [31:0] distance;

  pcfi_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_go), .operand(sqrt_arg),
    .done(sqrt_done), .root(sqrt_root)
  );

  pcfi_div u_div (
    .clk(clk), .rst(rst), .start(div_go), .numer(div_num), .denom(distance),
    .done(div_done), .quot(div_q)
  );

  // Working registers.
  logic signed [31:0] x_r, xp_r, v_r, xn_r, vn_r, pa_r, fs_r;
  logic [30:0]        ra_r;
  logic [31:0]        rsum, ov;
  logic               hit;
  logic signed [32:0] dv [3];
  logic [31:0]        uv [3];
  logic [63:0]        budget, s_acc;
  logic               r_contact;
  logic signed [31:0] r_force [3];
  logic signed [31:0] r_newp [3];
  logic signed [31:0] r_newv [3];

  // Combinational datapath values.
  logic signed [31:0] acc_c, xn_v, vn_e, xn_e, fs_c, prev_ld, fa_new, fb_new, vn_v;
  logic signed [32:0] d_c, d_neg, diff_c, q_signed;
  logic [31:0]        u_c;
  logic [64:0]        sq_sum;
  logic               sq_fail, u_ok, can_out;

  assign acc_c    = sat32(mul_res);
  assign fs_c     = sat32(mul_res);
  assign vn_v     = sat32(mul_res);
  assign xn_v     = sat32((sx66(x_r) <<< 1) - sx66(xp_r) + mul_res);
  assign vn_e     = sat32(sx66(v_r) + mul_res);
  assign xn_e     = sat32(sx66(x_r) + mul_res);
  assign prev_ld  = sat32(sx66(pos_in[ax]) - mul_res);
  assign fa_new   = sat32(sx66(frc_rd) - sx66(fs_r));
  assign fb_new   = sat32(sx66(frc_rd) + sx66(fs_r));
  assign diff_c   = sx33(xn_v) - sx33(xp_r);
  assign d_c      = sx33(pos_rd) - sx33(pa_r);
  assign d_neg    = -d_c;
  assign u_c      = d_c[32] ? d_neg[31:0] : d_c[31:0];
  assign u_ok     = hit && (u_c < rsum);
  assign sq_sum   = {1'b0, s_acc} + {1'b0, mul_p[63:0]};
  assign sq_fail  = (sq_sum >= {1'b0, budget});
  assign q_signed = dv[ax][32] ? (33'sd0 - $signed({1'b0, div_q})) : $signed({1'b0, div_q});
  assign can_out  = !res_valid || res_ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          if (!in_range) begin
            state_next = S_DONE;
          end else begin
            unique case (pcfi_cmd_t'(command))
              CMD_LOAD:    state_next = S_LD_MUL;
              CMD_CLEAR:   state_next = S_CLR;
              CMD_CONTACT: state_next = S_CT_RA;
              CMD_MOVE:    state_next = S_MV_RD;
            endcase
          end
        end
      end
      S_MWAIT:   state_next = mul_ret;
      S_DONE:    state_next = can_out ? S_IDLE : S_DONE;
      S_LD_MUL:  state_next = S_MWAIT;
      S_LD_WR:   state_next = (ax == 2'd2) ? S_DONE : S_LD_MUL;
      S_CLR:     state_next = (ax == 2'd2) ? S_DONE : S_CLR;
      S_MV_RD:   state_next = S_MV_ACC;
      S_MV_ACC:  state_next = S_MWAIT;
      S_MV_AT:   state_next = S_MWAIT;
      S_MV_VB:   state_next = S_MWAIT;
      S_MV_VC:   state_next = S_MWAIT;
      S_MV_VD:   state_next = (ax == 2'd2) ? S_DONE : S_MV_RD;
      S_MV_E1:   state_next = S_MWAIT;
      S_MV_E2:   state_next = (ax == 2'd2) ? S_DONE : S_MV_RD;
      S_CT_RA:   state_next = S_CT_RB;
      S_CT_RB:   state_next = S_CT_RS;
      S_CT_RS:   state_next = S_CT_PA;
      S_CT_PA:   state_next = S_CT_PB;
      S_CT_PB:   state_next = S_CT_D;
      S_CT_D: begin
        if (ax == 2'd2) state_next = u_ok ? S_CT_BG : S_DONE;
        else            state_next = S_CT_PA;
      end
      S_CT_BG:   state_next = S_MWAIT;
      S_CT_BG2:  state_next = S_CT_SQ;
      S_CT_SQ:   state_next = S_MWAIT;
      S_CT_SQ2: begin
        if (sq_fail)          state_next = S_DONE;
        else if (ax == 2'd2)  state_next = S_CT_ROOT;
        else                  state_next = S_CT_SQ;
      end
      S_CT_ROOT: begin
        if (sqrt_done) state_next = (sqrt_root == 32'd0) ? S_DONE : S_CT_F0;
      end
      S_CT_F0:   state_next = S_MWAIT;
      S_CT_F1:   state_next = S_CT_F2;
      S_CT_F2:   state_next = div_done ? S_MWAIT : S_CT_F2;
      S_CT_F3:   state_next = S_CT_F4;
      S_CT_F4:   state_next = S_CT_F5;
      S_CT_F5:   state_next = (ax == 2'd2) ? S_DONE : S_CT_F0;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Memory, multiplier and unit controls.
  always_comb begin
    pos_raddr  = addr_a;
    frc_raddr  = addr_a;
    rad_raddr  = RW'(a_r);
    mem_waddr  = addr_a;
    frc_waddr  = addr_a;
    pos_we     = 1'b0;
    prev_we    = 1'b0;
    vel_we     = 1'b0;
    frc_we     = 1'b0;
    rad_we     = 1'b0;
    pos_wdata  = '0;
    prev_wdata = '0;
    vel_wdata  = '0;
    frc_wdata  = '0;
    mul_go     = 1'b0;
    mi_a       = '0;
    mi_b       = '0;
    mi_s32     = 1'b0;
    mi_ret     = S_IDLE;
    sqrt_go    = 1'b0;
    sqrt_arg   = sq_sum[63:0];
    div_go     = 1'b0;
    div_num    = 65'(mul_p[63:0]) + 65'(distance[31:1]);
    unique case (state)
      S_LD_MUL: begin
        mul_go = 1'b1; mi_a = sx33(vel_in[ax]); mi_b = time_step; mi_s32 = 1'b1;
        mi_ret = S_LD_WR;
      end
      S_LD_WR: begin
        pos_we = 1'b1;  pos_wdata  = pos_in[ax];
        vel_we = 1'b1;  vel_wdata  = vel_in[ax];
        prev_we = 1'b1; prev_wdata = prev_ld;
        frc_we = 1'b1;  frc_wdata  = '0;
        rad_we = (ax == 2'd2);
      end
      S_CLR: begin
        frc_we = 1'b1; frc_wdata = '0;
      end
      S_MV_ACC: begin
        mul_go = 1'b1; mi_a = sx33(frc_rd); mi_b = inv_mass; mi_s32 = 1'b0;
        mi_ret = S_MV_AT;
      end
      S_MV_AT: begin
        mul_go = 1'b1; mi_a = sx33(acc_c); mi_b = time_step; mi_s32 = 1'b1;
        mi_ret = verlet_mode ? S_MV_VB : S_MV_E1;
      end
      S_MV_VB: begin
        mul_go = 1'b1; mi_a = mul_res[32:0]; mi_b = time_step; mi_s32 = 1'b1;
        mi_ret = S_MV_VC;
      end
      S_MV_VC: begin
        mul_go = 1'b1; mi_a = diff_c; mi_b = inv_double_step; mi_s32 = 1'b0;
        mi_ret = S_MV_VD;
      end
      S_MV_VD: begin
        pos_we = 1'b1;  pos_wdata  = xn_r;
        vel_we = 1'b1;  vel_wdata  = vn_v;
        prev_we = 1'b1; prev_wdata = x_r;
      end
      S_MV_E1: begin
        mul_go = 1'b1; mi_a = sx33(vn_e); mi_b = time_step; mi_s32 = 1'b1;
        mi_ret = S_MV_E2;
      end
      S_MV_E2: begin
        pos_we = 1'b1; pos_wdata = xn_e;
        vel_we = 1'b1; vel_wdata = vn_r;
      end
      S_CT_RB: rad_raddr = RW'(b_r);
      S_CT_PB: pos_raddr = addr_b;
      S_CT_BG: begin
        mul_go = 1'b1; mi_a = $signed({1'b0, rsum}); mi_b = rsum; mi_ret = S_CT_BG2;
      end
      S_CT_SQ: begin
        mul_go = 1'b1; mi_a = $signed({1'b0, uv[ax]}); mi_b = uv[ax]; mi_ret = S_CT_SQ2;
      end
      S_CT_SQ2: sqrt_go = !sq_fail && (ax == 2'd2);
      S_CT_F0: begin
        mul_go = 1'b1; mi_a = $signed({1'b0, ov}); mi_b = uv[ax]; mi_ret = S_CT_F1;
      end
      S_CT_F1: div_go = 1'b1;
      S_CT_F2: begin
        mul_go = div_done; mi_a = q_signed; mi_b = stiffness; mi_s32 = 1'b0;
        mi_ret = S_CT_F3;
      end
      S_CT_F4: begin
        // A nonzero distance means the two particles differ, so the write to the first
        // and the read of the second never touch the same entry.
        frc_we = 1'b1; frc_wdata = fa_new;
        frc_raddr = addr_b;
      end
      S_CT_F5: begin
        frc_we = 1'b1; frc_waddr = addr_b; frc_wdata = fb_new;
      end
      default: ;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ax <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_r     <= command;
            a_r       <= index_a;
            b_r       <= index_b;
            base_a    <= AW'(32'(index_a) * 3);
            base_b    <= AW'(32'(index_b) * 3);
            pos_in[0] <= pos_x;
            pos_in[1] <= pos_y;
            pos_in[2] <= pos_z;
            vel_in[0] <= vel_x;
            vel_in[1] <= vel_y;
            vel_in[2] <= vel_z;
            rad_in    <= radius;
            ax        <= '0;
            r_contact <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              r_force[i] <= '0;
              r_newp[i]  <= '0;
              r_newv[i]  <= '0;
            end
          end
        end
        S_LD_WR, S_CLR, S_CT_F5: ax <= ax + 2'd1;
        S_MV_ACC: begin
          x_r  <= pos_rd;
          xp_r <= prev_rd;
          v_r  <= vel_rd;
        end
        S_MV_VC: xn_r <= xn_v;
        S_MV_VD: begin
          r_newp[ax] <= xn_r;
          r_newv[ax] <= vn_v;
          ax         <= ax + 2'd1;
        end
        S_MV_E1: vn_r <= vn_e;
        S_MV_E2: begin
          r_newp[ax] <= xn_e;
          r_newv[ax] <= vn_r;
          ax         <= ax + 2'd1;
        end
        S_CT_RB: ra_r <= rad_rd;
        S_CT_RS: begin
          rsum <= {1'b0, ra_r} + {1'b0, rad_rd};
          hit  <= (({1'b0, ra_r} + {1'b0, rad_rd}) != 32'd0);
          ax   <= '0;
        end
        S_CT_PB: pa_r <= pos_rd;
        S_CT_D: begin
          dv[ax] <= d_c;
          uv[ax] <= u_c;
          hit    <= u_ok;
          ax     <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
        end
        S_CT_BG2: begin
          budget <= mul_p[63:0];
          s_acc  <= '0;
          ax     <= '0;
        end
        S_CT_SQ2: begin
          if (sq_fail) begin
            hit <= 1'b0;
          end else begin
            s_acc <= sq_sum[63:0];
            ax    <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
          end
        end
        S_CT_ROOT: begin
          if (sqrt_done) begin
            distance  <= sqrt_root;
            ov        <= rsum - sqrt_root;
            r_contact <= 1'b1;
            ax        <= '0;
          end
        end
        S_CT_F3: begin
          fs_r        <= fs_c;
          r_force[ax] <= fs_c;
        end
        default: ;
      endcase
    end
  end

  // Output register: holds one finished result while the next command is worked on.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_DONE && can_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && can_out) begin
      kind       <= cmd_r;
      in_contact <= r_contact;
      force_x    <= r_force[0];
      force_y    <= r_force[1];
      force_z    <= r_force[2];
      new_x      <= r_newp[0];
      new_y      <= r_newp[1];
      new_z      <= r_newp[2];
      new_vx     <= r_newv[0];
      new_vy     <= r_newv[1];
      new_vz     <= r_newv[2];
    end
  end
endmodule

[hdl/pcfi_sqrt.sv]
// Iterative integer square root, two radicand bits per cycle.
module pcfi_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] operand,
  output logic        done,
  output logic [31:0] root
);
  import pcfi_pkg::*;

  logic [63:0] op;
  logic [33:0] rem;
  logic [5:0]  cnt;
  logic        run;
  logic [35:0] rem_sh;
  logic [35:0] trial;

  assign rem_sh = {rem, op[63:62]};
  assign trial  = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        op   <= operand;
        rem  <= '0;
        root <= '0;
        cnt  <= 6'd32;
        run  <= 1'b1;
      end else if (run) begin
        if (rem_sh >= trial) begin
          rem  <= 34'(rem_sh - trial);
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= rem_sh[33:0];
          root <= {root[30:0], 1'b0};
        end
        op  <= {op[61:0], 2'b00};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[hdl/pcfi_div.sv]
// Restoring divider, one quotient bit per cycle; the quotient is known to fit 32 bits.
module pcfi_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [64:0] numer,
  input  logic [31:0] denom,
  output logic        done,
  output logic [31:0] quot
);
  import pcfi_pkg::*;

  logic [64:0] num;
  logic [31:0] den;
  logic [31:0] rem;
  logic [6:0]  cnt;
  logic        run;
  logic [32:0] rem_sh;

  assign rem_sh = {rem, num[64]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num  <= numer;
        den  <= denom;
        rem  <= '0;
        quot <= '0;
        cnt  <= 7'd65;
        run  <= 1'b1;
      end else if (run) begin
        if (rem_sh >= {1'b0, den}) begin
          rem  <= 32'(rem_sh - {1'b0, den});
          quot <= {quot[30:0], 1'b1};
        end else begin
          rem  <= rem_sh[31:0];
          quot <= {quot[30:0], 1'b0};
        end
        num <= {num[63:0], 1'b0};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
